// ===== rtl/lpcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_pkg
// shared types of the linear sample to pcm byte converter
// ----------------------------------------------------------------------------
package lpcm_pkg;

    // one coded sample: first byte in word[15:8], second byte in word[7:0]
    typedef struct packed {
        logic [15:0] word;
        logic        two;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/lpcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_in_if / lpcm_out_if
// valid/ready channels for linear samples and coded pcm bytes
// ----------------------------------------------------------------------------
interface lpcm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lpcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/lpcm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_front
// format register, sample accept and coding into a one or two byte entry
// ----------------------------------------------------------------------------
module lpcm_front
    import lpcm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    lpcm_in_if.sink         in_ch,
    output entry_t          push_entry,
    output logic            push_valid,
    input  wire logic       push_ready
);

    typedef enum logic [3:0] {
        FMT_AU1  = 4'd0,
        FMT_S8   = 4'd1,
        FMT_U8   = 4'd2,
        FMT_S16B = 4'd3,
        FMT_U16B = 4'd4,
        FMT_S16L = 4'd5,
        FMT_U16L = 4'd6,
        FMT_ULAW = 4'd7,
        FMT_AU2  = 4'd8,
        FMT_AU3  = 4'd9,
        FMT_ALAW = 4'd10
    } fmt_t;

    logic [3:0] fmt_reg;

    // g.711 mu-law: bias 0x84, clip 32635, inverted code
    function automatic logic [7:0] mulaw_code(input logic [15:0] x);
        logic       sign;
        logic [15:0] mag;
        logic [2:0] ex;
        logic [3:0] mant;
        sign = x[15];
        mag  = sign ? 16'(~x + 16'd1) : x;
        if (mag > 16'd32635)
            mag = 16'd32635;
        mag = mag + 16'h0084;
        ex  = 3'd0;
        for (int i = 1; i < 8; i++)
            if (mag[i + 7])
                ex = 3'(i);
        mant = 4'(mag >> ({1'b0, ex} + 4'd3));
        return ~{sign, ex, mant};
    endfunction

    // g.711 a-law on the 13-bit floor of x / 8
    function automatic logic [7:0] alaw_code(input logic [15:0] x);
        logic [12:0] v;
        logic [11:0] mag;
        logic [7:0]  mask;
        logic [2:0]  seg;
        logic [3:0]  low;
        v    = x[15:3];
        mag  = v[12] ? ~v[11:0] : v[11:0];
        mask = v[12] ? 8'h55 : 8'hd5;
        seg  = 3'd0;
        for (int i = 1; i < 8; i++)
            if (mag[i + 4])
                seg = 3'(i);
        if (seg < 3'd2)
            low = mag[4:1];
        else
            low = 4'(mag >> seg);
        return {1'b0, seg, low} ^ mask;
    endfunction

    logic signed [31:0] s;
    logic [15:0]        g711_x;
    logic [15:0]        s16_word;
    logic [15:0]        u16_word;
    logic [7:0]         au3_byte;
    logic               known_fmt;

    assign s = in_ch.sample;

    // sample * 8 capped at 32767, low 16 bits kept
    assign g711_x   = (s > 32'sd4095) ? 16'h7fff : {s[12:0], 3'b000};
    assign s16_word = (s > 32'sd32767) ? 16'h7fff : s[15:0];
    assign u16_word = (s > 32'sd65535) ? 16'hffff : s[15:0];
    assign au3_byte = s[31] ? ((8'd127 - s[7:0]) ^ 8'hd5) : ((s[7:0] + 8'd128) ^ 8'h55);

    always_comb
    begin
        push_entry = '{word: 16'h0000, two: 1'b0};
        known_fmt  = 1'b1;
        unique case (fmt_reg)
            FMT_AU1, FMT_AU2:
                push_entry.word[15:8] = s[7:0];
            FMT_S8:
                push_entry.word[15:8] = (s > 32'sd127) ? 8'd127 : s[7:0];
            FMT_U8:
                push_entry.word[15:8] = (s > 32'sd255) ? 8'd255 : s[7:0];
            FMT_ULAW:
                push_entry.word[15:8] = mulaw_code(g711_x);
            FMT_ALAW:
                push_entry.word[15:8] = alaw_code(g711_x);
            FMT_AU3:
                push_entry.word[15:8] = au3_byte;
            FMT_S16B:
                push_entry = '{word: s16_word, two: 1'b1};
            FMT_U16B:
                push_entry = '{word: u16_word, two: 1'b1};
            FMT_S16L:
                push_entry = '{word: {s16_word[7:0], s16_word[15:8]}, two: 1'b1};
            FMT_U16L:
                push_entry = '{word: {u16_word[7:0], u16_word[15:8]}, two: 1'b1};
            default:
                known_fmt = 1'b0;
        endcase
    end

    // unknown formats are accepted and dropped
    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid && known_fmt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_S16B;
        else if (cfg_wr_en)
            fmt_reg <= cfg_wr_data;
    end

endmodule
`default_nettype wire

// ===== rtl/lpcm_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_fifo
// short queue of coded entries between front and back
// ----------------------------------------------------------------------------
module lpcm_fifo
    import lpcm_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t push_entry,
    input  wire logic   push_valid,
    output logic        push_ready,
    output entry_t      pop_entry,
    output logic        pop_valid,
    input  wire logic   pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

// ===== rtl/lpcm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_back
// serializes queued entries into bytes through the output register
// ----------------------------------------------------------------------------
module lpcm_back
    import lpcm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t pop_entry,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    lpcm_out_if.source  out_ch
);

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;

    // output register free or being drained this cycle
    assign load      = !valid_reg || out_ch.ready;
    assign pop_ready = load && (!pop_entry.two || phase_reg);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = pop_valid;
            if (pop_valid)
            begin
                byte_next  = phase_reg ? pop_entry.word[7:0] : pop_entry.word[15:8];
                last_next  = !pop_entry.two || phase_reg;
                phase_next = pop_entry.two && !phase_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_byte  = byte_reg;
    assign out_ch.last_byte = last_reg;

endmodule
`default_nettype wire

// ===== rtl/linear_sample_to_pcm_bytes_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_sample_to_pcm_bytes_top
// converts signed linear samples into pcm byte streams of a selected format
// ----------------------------------------------------------------------------
// Each request on sample_ch carries one signed 32-bit sample; the block answers
// with one byte (8-bit, au1/au2/au3, mu-law, a-law) or two bytes (16-bit formats,
// big or little endian) on byte_ch, last_byte marking the final byte of a sample.
// Format codes 11 to 15 accept the sample and produce nothing. The format comes
// from cfg_wr_data, taken on a clock edge with cfg_wr_en high (reset value 3,
// s16 big endian); change it only while no sample is in flight. The front codes
// a sample in the cycle it is accepted and writes it into a QUEUE_DEPTH entry
// queue; the back drains the queue one byte per cycle into the output register
// while byte_ch is ready. Throughput is set by that single byte-wide output
// register: with byte_ch ready, one sample per cycle for one-byte formats; a
// 16-bit sample sends its two bytes through it one after the other. The first
// byte passes through the queue and then the output register onto byte_ch.
// ----------------------------------------------------------------------------
module linear_sample_to_pcm_bytes_top
    import lpcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    lpcm_in_if.sink         sample_ch,
    lpcm_out_if.source      byte_ch
);

    // coded entry between front and queue
    entry_t push_entry;
    logic   push_valid;
    logic   push_ready;

    // head entry between queue and back
    entry_t pop_entry;
    logic   pop_valid;
    logic   pop_ready;

    // format register, accept and coding
    lpcm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (sample_ch),
        .push_entry  (push_entry),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    // decouples coding from byte output
    lpcm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // byte serializer with registered output
    lpcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .out_ch    (byte_ch)
    );

endmodule
`default_nettype wire
